// ----- rtl/core/pcx_pkg.sv -----
// ----------------------------------------------------------------------------
// pcx_pkg
// Shared types and constants of the PCX run-length decoder.
// ----------------------------------------------------------------------------
package pcx_pkg;

    // Byte classification.
    localparam logic [7:0] HDR_MASK   = 8'hC0;
    localparam logic [7:0] COUNT_MASK = 8'h3F;

    localparam int unsigned CountWidth = 6;
    localparam int unsigned LineWidth  = 16;

    // One pixel run handed from the front end to the expander.
    typedef struct packed {
        logic [7:0]            pixel;
        logic [CountWidth-1:0] count;
    } cmd_t;

endpackage

// ----- rtl/core/pcx_front.sv -----
// ----------------------------------------------------------------------------
// pcx_front
// Accepts encoded bytes, classifies them and issues run commands.
// ----------------------------------------------------------------------------
module pcx_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    in_byte,
    output logic          cmd_push,
    output pcx_pkg::cmd_t cmd_data,
    input  logic          cmd_full
);

    logic                              awaiting_reg;
    logic                              awaiting_next;
    logic [pcx_pkg::CountWidth-1:0]    pending_reg;
    logic [pcx_pkg::CountWidth-1:0]    pending_next;
    logic                              accept;
    logic                              is_header;

    assign in_ready  = !cmd_full;
    assign accept    = in_valid && in_ready;
    assign is_header = (in_byte & pcx_pkg::HDR_MASK) == pcx_pkg::HDR_MASK;

    always_comb begin
        awaiting_next  = awaiting_reg;
        pending_next   = pending_reg;
        cmd_push       = 1'b0;
        cmd_data.pixel = in_byte;
        cmd_data.count = pending_reg;
        if (accept) begin
            if (awaiting_reg) begin
                // A value byte is always a value; a zero count yields nothing.
                awaiting_next = 1'b0;
                pending_next  = '0;
                cmd_push      = pending_reg != '0;
            end else if (is_header) begin
                awaiting_next = 1'b1;
                pending_next  = in_byte[pcx_pkg::CountWidth-1:0];
            end else begin
                cmd_push       = 1'b1;
                cmd_data.count = pcx_pkg::CountWidth'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            awaiting_reg <= 1'b0;
            pending_reg  <= '0;
        end else begin
            awaiting_reg <= awaiting_next;
            pending_reg  <= pending_next;
        end
    end

endmodule

// ----- rtl/core/pcx_cmd_queue.sv -----
// ----------------------------------------------------------------------------
// pcx_cmd_queue
// Small register queue of run commands between front end and expander.
// ----------------------------------------------------------------------------
module pcx_cmd_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  pcx_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          pop_valid,
    output pcx_pkg::cmd_t pop_data
);

    localparam int unsigned PtrWidth = $clog2(DEPTH);
    localparam int unsigned CntWidth = $clog2(DEPTH + 1);
    localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(DEPTH - 1);
    localparam logic [CntWidth-1:0] FullCnt = CntWidth'(DEPTH);

    pcx_pkg::cmd_t          mem_reg [DEPTH];
    logic [PtrWidth-1:0]    wr_ptr_reg;
    logic [PtrWidth-1:0]    wr_ptr_next;
    logic [PtrWidth-1:0]    rd_ptr_reg;
    logic [PtrWidth-1:0]    rd_ptr_next;
    logic [CntWidth-1:0]    cnt_reg;
    logic [CntWidth-1:0]    cnt_next;
    logic                   do_push;
    logic                   do_pop;

    assign full      = cnt_reg == FullCnt;
    assign pop_valid = cnt_reg != '0;
    assign pop_data  = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/core/pcx_back.sv -----
// ----------------------------------------------------------------------------
// pcx_back
// Expands run commands into pixels, tracks the column, drives the output.
// ----------------------------------------------------------------------------
module pcx_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [pcx_pkg::LineWidth-1:0] line_length,
    input  logic                          cmd_valid,
    input  pcx_pkg::cmd_t                 cmd_data,
    output logic                          cmd_pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [7:0]                    out_pixel,
    output logic                          out_line_end,
    output logic                          out_last
);

    logic                              active_reg;
    logic                              active_next;
    logic [pcx_pkg::CountWidth-1:0]    remaining_reg;
    logic [pcx_pkg::CountWidth-1:0]    remaining_next;
    logic [7:0]                        value_reg;
    logic [7:0]                        value_next;
    logic [pcx_pkg::LineWidth-1:0]     column_reg;
    logic [pcx_pkg::LineWidth-1:0]     column_next;
    logic                              valid_reg;
    logic                              valid_next;
    logic [7:0]                        pixel_reg;
    logic [7:0]                        pixel_next;
    logic                              line_end_reg;
    logic                              line_end_next;
    logic                              last_reg;
    logic                              last_next;
    logic                              produce;
    logic                              final_pixel;
    logic [pcx_pkg::LineWidth:0]       col_inc;
    logic                              ends;

    assign produce     = active_reg && (!valid_reg || out_ready);
    assign final_pixel = remaining_reg == pcx_pkg::CountWidth'(1);
    assign cmd_pop     = !active_reg || (produce && final_pixel);
    assign col_inc     = {1'b0, column_reg} + 1'b1;
    assign ends        = col_inc >= {1'b0, line_length};

    always_comb begin
        active_next    = active_reg;
        remaining_next = remaining_reg;
        value_next     = value_reg;
        column_next    = column_reg;
        valid_next     = valid_reg && !out_ready;
        pixel_next     = pixel_reg;
        line_end_next  = line_end_reg;
        last_next      = last_reg;
        if (produce) begin
            valid_next     = 1'b1;
            pixel_next     = value_reg;
            line_end_next  = ends;
            last_next      = final_pixel;
            column_next    = ends ? '0 : col_inc[pcx_pkg::LineWidth-1:0];
            remaining_next = remaining_reg - 1'b1;
            active_next    = !final_pixel;
        end
        if (cmd_pop && cmd_valid) begin
            active_next    = 1'b1;
            remaining_next = cmd_data.count;
            value_next     = cmd_data.pixel;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            remaining_reg <= '0;
            column_reg    <= '0;
            valid_reg     <= 1'b0;
        end else begin
            active_reg    <= active_next;
            remaining_reg <= remaining_next;
            column_reg    <= column_next;
            valid_reg     <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg    <= value_next;
        pixel_reg    <= pixel_next;
        line_end_reg <= line_end_next;
        last_reg     <= last_next;
    end

    assign out_valid    = valid_reg;
    assign out_pixel    = pixel_reg;
    assign out_line_end = line_end_reg;
    assign out_last     = last_reg;

endmodule

// ----- rtl/core/pcx_rle_decoder.sv -----
// ----------------------------------------------------------------------------
// pcx_rle_decoder
// PCX run-length decoder with scan-line end marking.
// ----------------------------------------------------------------------------
// The slave channel takes one encoded byte per item in s_tdata. A byte with
// both top bits set is a run header, and the byte after it is the pixel value
// repeated as often as the header's low six bits say; any other byte is one
// literal pixel. The master channel gives one decoded pixel per item in
// m_tdata, with m_tuser high on the pixel that completes a scan line and
// m_tlast high on the last pixel caused by one input byte.
// The line length is written through cfg_we and cfg_wdata while idle.
// A front end classifies bytes and pushes run commands into a short queue;
// an expander behind it emits one pixel per cycle unless the output stalls,
// so a run holds the output while the front end keeps accepting. The first
// pixel of a byte passes the queue, the run registers and output register.
// Literal bytes are taken one per cycle; long runs fill the queue, and then
// s_tready drops until the expander has caught up.
// When the receiver stalls, the output register holds its item and the
// expander waits. Reset clears the queue, the column and pending header and
// sets the line length to 640.
// ----------------------------------------------------------------------------
module pcx_rle_decoder #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration: line length in pixels.
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    // Encoded input. s_tdata: [7:0] code_byte.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    // Decoded output. m_tdata: [7:0] pixel. m_tuser: [0] line_end.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,
    output logic [0:0]  m_tuser,
    output logic        m_tlast
);

    localparam logic [pcx_pkg::LineWidth-1:0] LineReset = 16'd640;

    logic [pcx_pkg::LineWidth-1:0] line_length_reg;
    logic                          cmd_push;
    pcx_pkg::cmd_t                 cmd_in;
    logic                          cmd_full;
    logic                          cmd_pop;
    logic                          cmd_valid;
    pcx_pkg::cmd_t                 cmd_out;
    logic                          line_end;

    // The line length register; writes leave the column untouched.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_length_reg <= LineReset;
        end else if (cfg_we) begin
            line_length_reg <= cfg_wdata;
        end
    end

    pcx_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .cmd_push (cmd_push),
        .cmd_data (cmd_in),
        .cmd_full (cmd_full)
    );

    pcx_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (cmd_push),
        .push_data (cmd_in),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .pop_valid (cmd_valid),
        .pop_data  (cmd_out)
    );

    pcx_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .line_length  (line_length_reg),
        .cmd_valid    (cmd_valid),
        .cmd_data     (cmd_out),
        .cmd_pop      (cmd_pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_pixel    (m_tdata),
        .out_line_end (line_end),
        .out_last     (m_tlast)
    );

    assign m_tuser = line_end;

endmodule

// ----- test/tb_pcx_rle_decoder.sv -----
// ----------------------------------------------------------------------------
// tb_pcx_rle_decoder
// Self-checking testbench for the PCX run-length decoder.
// ----------------------------------------------------------------------------
// Encoded bytes go in through the slave stream, and every decoded pixel that
// leaves through the master stream is checked against a behavioural decoder
// held in this file. The test opens with a short table of directed rows:
// literals at the edges of the literal range, zero and full-length runs, a
// value byte that looks like a header, and line-length writes that fall
// mid-line. Random phases follow, each with its own line length: mostly
// well-formed literal and run sequences, now and then a header left hanging
// across a register write. The sender works in bursts, the receiver stalls
// in moods of its own, and once the receiver holds off for a long stretch so
// that the run queue fills and the input stalls.
// ----------------------------------------------------------------------------
module tb_pcx_rle_decoder;

    timeunit 1ns;
    timeprecision 1ps;

    // Length of the random part, in encoded items.
    localparam int RandomItems   = 256;
    // Cycles allowed for the pipeline to empty before a register write. This
    // leaves a good margin for headers and zero-count runs, which give no
    // pixel to wait for.
    localparam int SettleCycles  = 12;
    // The one long hold-off of the receiver.
    localparam int HoldCycles    = 400;
    // Cycles with no handshake on any port before the run is abandoned. The
    // longest quiet stretch of a correct run is the hold-off above.
    localparam int WatchdogLimit = 5000;
    localparam int MaxReports    = 10;

    // One decoded pixel as the master stream carries it.
    typedef struct packed {
        logic [7:0] pixel;
        logic       line_end;
        logic       last;
    } pix_t;

    localparam pix_t NoPix = '0;

    // A directed row either sends one encoded byte or writes the line length.
    typedef enum logic {
        ROW_BYTE,
        ROW_LEN
    } row_kind_e;

    typedef struct {
        row_kind_e   kind;
        logic [15:0] value;
        bit          typed;
        pix_t        pix;
    } row_t;

    // Moods of the receiver.
    typedef enum logic [1:0] {
        RX_READY,
        RX_MOSTLY,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mood_e;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;

    pcx_rle_decoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [7:0] code_byte
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // [7:0] pixel
        .m_tuser   (m_tuser),    // [0] line_end
        .m_tlast   (m_tlast)
    );

    // State of the behavioural decoder, kept in step with the block. It is
    // advanced at the clock edge at which an item or a register write is
    // taken.
    logic        run_pending;
    logic [5:0]  run_count;
    logic [15:0] cur_column;
    logic [15:0] cur_len;

    // Pixels that the block still owes, oldest first.
    pix_t pixels_due[$];

    // Sender burst state and the hold-off request to the receiver.
    int  burst_left;
    bit  in_pressure;
    bit  hold_req;

    // Run statistics.
    int items_taken;
    int random_taken;
    int len_writes;
    int pixels_checked;
    int line_ends_seen;
    int input_stalls;
    int mismatches;

    // The directed table. Pixels are typed in only where they are plain to
    // see: literals straight after reset, where the line is far from its end,
    // and single pixels that must end the line once the length has been cut
    // below the current column or set to one.
    row_t dir_rows[$] = '{
        '{ROW_BYTE, 16'h0000,                          1'b1, '{8'h00, 1'b0, 1'b1}},
        '{ROW_BYTE, 16'h00BF,                          1'b1, '{8'hBF, 1'b0, 1'b1}},
        '{ROW_BYTE, 16'h0080,                          1'b1, '{8'h80, 1'b0, 1'b1}},
        '{ROW_BYTE, 16'h007F,                          1'b1, '{8'h7F, 1'b0, 1'b1}},
        // A run of zero swallows its value byte and gives nothing.
        '{ROW_BYTE, 16'(pcx_pkg::HDR_MASK | 8'd0),     1'b0, NoPix},
        '{ROW_BYTE, 16'h0055,                          1'b0, NoPix},
        // The longest run, with a value that itself looks like a header.
        '{ROW_BYTE, 16'(pcx_pkg::HDR_MASK | 8'd63),    1'b0, NoPix},
        '{ROW_BYTE, 16'h00FF,                          1'b0, NoPix},
        '{ROW_BYTE, 16'(pcx_pkg::HDR_MASK | 8'd1),     1'b0, NoPix},
        '{ROW_BYTE, 16'h00C0,                          1'b0, NoPix},
        '{ROW_BYTE, 16'(pcx_pkg::HDR_MASK | 8'd3),     1'b0, NoPix},
        '{ROW_BYTE, 16'h0000,                          1'b0, NoPix},
        '{ROW_BYTE, 16'h0001,                          1'b0, NoPix},
        '{ROW_BYTE, 16'(pcx_pkg::HDR_MASK | 8'd62),    1'b0, NoPix},
        '{ROW_BYTE, 16'h00AA,                          1'b0, NoPix},
        // A short line while the column is far past it, then a run that
        // ends the line at three of its pixels.
        '{ROW_LEN,  16'd3,                             1'b0, NoPix},
        '{ROW_BYTE, 16'(pcx_pkg::HDR_MASK | 8'd7),     1'b0, NoPix},
        '{ROW_BYTE, 16'h0012,                          1'b0, NoPix},
        '{ROW_LEN,  16'hFFFF,                          1'b0, NoPix},
        '{ROW_BYTE, 16'h0011,                          1'b0, NoPix},
        '{ROW_BYTE, 16'h0022,                          1'b0, NoPix},
        '{ROW_BYTE, 16'h0033,                          1'b0, NoPix},
        // The column now stands at three, so the next pixel ends the line.
        '{ROW_LEN,  16'd2,                             1'b1, NoPix},
        '{ROW_BYTE, 16'h0044,                          1'b1, '{8'h44, 1'b1, 1'b1}},
        '{ROW_LEN,  16'd1,                             1'b0, NoPix},
        '{ROW_BYTE, 16'h003C,                          1'b1, '{8'h3C, 1'b1, 1'b1}}
    };

    // Decodes one encoded byte: returns the pixels it causes and moves the
    // decoder state on. A line ends when the column plus one reaches the
    // line length, compared at seventeen bits so that no wrap can hide it.
    function automatic void decode_byte(input logic [7:0] code, output pix_t res[$]);
        int          n_pix;
        logic [16:0] next_col;
        logic        ends_line;
        n_pix = 0;
        res   = {};
        if (run_pending) begin
            // Whatever the byte looks like, it is the value of the run.
            n_pix       = run_count;
            run_pending = 1'b0;
            run_count   = '0;
        end else if ((code & pcx_pkg::HDR_MASK) == pcx_pkg::HDR_MASK) begin
            run_count   = 6'(code & pcx_pkg::COUNT_MASK);
            run_pending = 1'b1;
        end else begin
            n_pix = 1;
        end
        for (int i = 0; i < n_pix; i++) begin
            next_col   = {1'b0, cur_column} + 17'd1;
            ends_line  = next_col >= {1'b0, cur_len};
            res.push_back('{code, ends_line, (i + 1 == n_pix)});
            cur_column = ends_line ? 16'd0 : next_col[15:0];
        end
    endfunction

    // Clock: 2 ns period.
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Offers one encoded byte and waits until it is taken. Bursts of random
    // length are separated by random gaps, so that idle cycles fall at every
    // point of a run's expansion. During the pressure stretch there are no
    // gaps at all.
    task automatic send_byte(input logic [7:0] code, input bit use_typed,
                             input pix_t typed_pix);
        pix_t res[$];
        int   gap;
        if (burst_left == 0) begin
            gap = in_pressure ? 0 :
                  ($urandom_range(0, 99) < 15) ? $urandom_range(5, 20) :
                                                 $urandom_range(0, 3);
            repeat (gap) begin
                @(negedge aclk);
                s_tvalid = 1'b0;
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) :
                                                       $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = code;
        do @(posedge aclk); while (!s_tready);
        items_taken++;
        decode_byte(code, res);
        if (use_typed) begin
            pixels_due.push_back(typed_pix);
        end else begin
            foreach (res[i]) pixels_due.push_back(res[i]);
        end
    endtask

    // Withdraws the offer and waits until every owed pixel has arrived, then
    // for a few cycles more, since headers and empty runs leave nothing to
    // wait for.
    task automatic drain_pipeline();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pixels_due.size() != 0) @(posedge aclk);
        repeat (SettleCycles) @(posedge aclk);
    endtask

    // Writes the line length while the block is idle. The column is left
    // where it is, as the block does.
    task automatic write_line_length(input logic [15:0] len);
        drain_pipeline();
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_wdata = len;
        @(negedge aclk);
        cfg_we    = 1'b0;
        cur_len   = len;
        len_writes++;
    endtask

    // One well-formed unit of random stream: a literal, or a header and its
    // value. Runs are short most of the time so that many of them fit in the
    // run; the longest counts appear now and then, and always under pressure.
    task automatic send_random_unit();
        logic [5:0] count;
        if (!in_pressure && $urandom_range(0, 99) < 45) begin
            send_byte(8'($urandom_range(0, 8'hBF)), 1'b0, NoPix);
            random_taken++;
        end else begin
            count = in_pressure                     ? 6'd63 :
                    ($urandom_range(0, 9) < 7)      ? 6'($urandom_range(0, 8)) :
                                                      6'($urandom_range(0, 63));
            send_byte(pcx_pkg::HDR_MASK | 8'(count), 1'b0, NoPix);
            send_byte(8'($urandom_range(0, 255)), 1'b0, NoPix);
            random_taken += 2;
        end
    endtask

    // Stimulus and the end of the run.
    initial begin
        int phase;
        int units;
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        burst_left   = 0;
        in_pressure  = 1'b0;
        hold_req     = 1'b0;
        items_taken  = 0;
        random_taken = 0;
        len_writes   = 0;
        // The decoder comes out of reset with a 640-pixel line.
        run_pending  = 1'b0;
        run_count    = '0;
        cur_column   = '0;
        cur_len      = 16'd640;
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;

        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_LEN) begin
                write_line_length(dir_rows[r].value);
            end else begin
                send_byte(dir_rows[r].value[7:0], dir_rows[r].typed, dir_rows[r].pix);
            end
        end

        // Random phases, each with a line length of its own: the extremes,
        // the reset value, short lines that make runs wrap often, and any
        // length at all.
        phase = 0;
        while (random_taken < RandomItems) begin
            case ($urandom_range(0, 5))
                0: write_line_length(16'd1);
                1: write_line_length(16'hFFFF);
                2: write_line_length(16'd640);
                3: write_line_length(16'($urandom_range(1, 8)));
                4: write_line_length(16'($urandom_range(1, 80)));
                default: write_line_length(16'($urandom_range(1, 65535)));
            endcase
            if (phase == 2) begin
                // Ask the receiver to hold off, then push long runs back to
                // back until the run queue is full and the input stalls.
                @(posedge aclk);
                hold_req    = 1'b1;
                in_pressure = 1'b1;
                repeat (6) send_random_unit();
                in_pressure = 1'b0;
            end
            units = $urandom_range(12, 30);
            repeat (units) send_random_unit();
            // Sometimes the phase ends on a bare header, so that the run's
            // value arrives only after the next register write.
            if ($urandom_range(0, 9) == 0) begin
                send_byte(pcx_pkg::HDR_MASK | 8'($urandom_range(0, 63)), 1'b0, NoPix);
                random_taken++;
            end
            phase++;
        end

        drain_pipeline();
        $display("Sent %0d encoded items across %0d line-length writes; %0d pixels checked.",
                 items_taken, len_writes, pixels_checked);
        $display("Saw %0d line ends and %0d input stall cycles; %0d mismatches.",
                 line_ends_seen, input_stalls, mismatches);
        if (mismatches == 0) begin
            $display("pcx_rle_decoder test passed");
        end else begin
            $display("pcx_rle_decoder test failed");
        end
        $finish;
    end

    // Receiver. It drifts between moods of random length: always ready,
    // mostly ready, seldom ready and a fixed one-in-five stall. When the
    // sender asks for it, it holds off for a long stretch on its own count.
    initial begin
        rx_mood_e mood;
        int       mood_left;
        int       tick;
        mood      = RX_READY;
        mood_left = 0;
        tick      = 0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            tick++;
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready = 1'b0;
                repeat (HoldCycles - 1) @(negedge aclk);
            end else begin
                if (mood_left == 0) begin
                    mood      = rx_mood_e'($urandom_range(0, 3));
                    mood_left = $urandom_range(16, 96);
                end
                mood_left--;
                case (mood)
                    RX_READY:  m_tready = 1'b1;
                    RX_MOSTLY: m_tready = ($urandom_range(0, 3) != 0);
                    RX_SPARSE: m_tready = ($urandom_range(0, 2) == 0);
                    default:   m_tready = (tick % 5 != 0);
                endcase
            end
        end
    end

    // Pixel checker: every pixel taken from the master stream is compared,
    // field by field, with the oldest pixel owed. Values are shown as
    // pixel/line_end/last.
    initial begin
        pix_t want;
        bit   bad;
        pixels_checked = 0;
        line_ends_seen = 0;
        mismatches     = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                pixels_checked++;
                if (m_tuser[0]) line_ends_seen++;
                if (pixels_due.size() == 0) begin
                    if (mismatches < MaxReports) begin
                        $display("Unexpected pixel %02h line_end %0b last %0b",
                                 m_tdata, m_tuser[0], m_tlast);
                    end
                    mismatches++;
                end else begin
                    want = pixels_due.pop_front();
                    bad  = (m_tdata !== want.pixel) || (m_tuser[0] !== want.line_end) ||
                           (m_tlast !== want.last);
                    if (bad) begin
                        if (mismatches < MaxReports) begin
                            $display("Pixel %0d: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                                     pixels_checked, want.pixel, want.line_end, want.last,
                                     m_tdata, m_tuser[0], m_tlast);
                        end
                        mismatches++;
                    end
                end
            end
        end
    end

    // Watchdog: a run in which nothing moves for too long has hung.
    initial begin
        int quiet;
        quiet        = 0;
        input_stalls = 0;
        forever begin
            @(posedge aclk);
            if (s_tvalid && !s_tready && !m_tready) input_stalls++;
            if (!aresetn || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= WatchdogLimit) begin
                $display("Nothing moved for %0d cycles, %0d pixels still owed.",
                         quiet, pixels_due.size());
                $display("pcx_rle_decoder test failed");
                $finish;
            end
        end
    end

endmodule
